// ----- rtl/core/nmea_rmc_time_extractor_top_macros.svh -----
// Assertion helpers for the RMC time extractor.
// Both sample on the rising edge of clk and are held off during reset.
`ifndef NMEA_RMC_TIME_EXTRACTOR_TOP_MACROS_SVH
`define NMEA_RMC_TIME_EXTRACTOR_TOP_MACROS_SVH

// Same-cycle implication.
`define NRTE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nrte assertion failed");

// Next-cycle implication.
`define NRTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nrte assertion failed");

`endif

// ----- rtl/core/nrte_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nrte_pkg;

  // ASCII characters that steer the parser
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ACTIVE = 8'h41;

  // Hour offset after reset, and hours in a day
  localparam logic [4:0] OFFSET_RESET = 5'd8;
  localparam logic [5:0] HOURS_DAY    = 6'd24;

  // Sentence status codes
  localparam logic [2:0] ST_ACCEPTED   = 3'd0;
  localparam logic [2:0] ST_FORMAT     = 3'd1;
  localparam logic [2:0] ST_CHECKSUM   = 3'd2;
  localparam logic [2:0] ST_NOT_RMC    = 3'd3;
  localparam logic [2:0] ST_NOT_ACTIVE = 3'd4;

  // One result word
  typedef struct packed {
    logic [2:0] sentence_status;
    logic       time_valid;
    logic [4:0] local_hour;
    logic [5:0] local_minute;
    logic [5:0] local_second;
  } res_t;

  // Expected talker and sentence identifier, "GPRMC"
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h47;
      3'd1:    c = 8'h50;
      3'd2:    c = 8'h52;
      3'd3:    c = 8'h4D;
      3'd4:    c = 8'h43;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Hex digit decode: bit 4 flags a legal digit, bits 3:0 give its value
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] v;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = {1'b1, 4'(b - 8'h57)};
    end else begin
      v = 5'd0;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nrte_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nrte_parser (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step_en,
  input  wire logic [7:0]     data_byte,
  input  wire logic           last_byte,
  input  wire logic [4:0]     hour_offset,
  output nrte_pkg::res_t      res,
  output logic                res_valid
);

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_BODY,
    PH_SUM,
    PH_SKIP
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_s;
  logic [7:0]  xor_r, xor_nxt, xor_s;
  logic [7:0]  rsum_r, rsum_nxt, rsum_s;
  logic        ovf_r, ovf_nxt, ovf_s;
  logic [3:0]  field_r, field_nxt, field_s;
  logic [3:0]  cif_r, cif_nxt, cif_s;
  logic        hdr_r, hdr_nxt, hdr_s;
  logic        act_r, act_nxt, act_s;
  logic        fmt_r, fmt_nxt, fmt_s;
  logic [23:0] digits_r, digits_nxt;
  logic [4:0]  khour_r, khour_nxt;
  logic [5:0]  kmin_r, kmin_nxt;
  logic [5:0]  ksec_r, ksec_nxt;
  logic        have_r, have_nxt;

  logic [4:0]  hexv;
  logic [3:0]  nib;
  logic [3:0]  n0, n1, n2, n3, n4, n5;
  logic [6:0]  hh, mm, ss;
  logic        digits_ok, time_ok, fmt_end;
  logic [5:0]  hsum, hwrap;
  logic [2:0]  status;

  assign hexv = nrte_pkg::hex_val(data_byte);
  assign nib  = (data_byte >= 8'h30 && data_byte <= 8'h39) ? 4'(data_byte - 8'h30) : 4'hF;

  // Advance the sentence state by one byte
  always_comb begin
    phase_s    = phase_r;
    xor_s      = xor_r;
    rsum_s     = rsum_r;
    ovf_s      = ovf_r;
    field_s    = field_r;
    cif_s      = cif_r;
    hdr_s      = hdr_r;
    act_s      = act_r;
    fmt_s      = fmt_r;
    digits_nxt = digits_r;
    unique case (phase_r)
      PH_FIRST: begin
        digits_nxt = '1;
        if (data_byte == nrte_pkg::CH_DOLLAR) begin
          phase_s = PH_BODY;
        end else begin
          fmt_s   = 1'b1;
          phase_s = PH_SKIP;
        end
      end
      PH_BODY: begin
        if (data_byte == nrte_pkg::CH_STAR) begin
          if (field_r == 4'd0 && cif_r == 4'd0) fmt_s = 1'b1;
          if (field_r == 4'd0 && cif_r != 4'd5) hdr_s = 1'b0;
          phase_s = PH_SUM;
          cif_s   = 4'd0;
        end else begin
          xor_s = xor_r ^ data_byte;
          if (data_byte == nrte_pkg::CH_COMMA) begin
            if (field_r == 4'd0 && cif_r != 4'd5) hdr_s = 1'b0;
            if (field_r != 4'd15) field_s = field_r + 4'd1;
            cif_s = 4'd0;
          end else begin
            if (field_r == 4'd0) begin
              if (cif_r >= 4'd5 || nrte_pkg::hdr_char(cif_r[2:0]) != data_byte) begin
                hdr_s = 1'b0;
              end
            end else if (field_r == 4'd1) begin
              // place the digit, most significant first
              for (int k = 0; k < 6; k++) begin
                if (cif_r == 4'(k)) digits_nxt[4*(5-k) +: 4] = nib;
              end
            end else if (field_r == 4'd2) begin
              if (cif_r == 4'd0 && data_byte == nrte_pkg::CH_ACTIVE) act_s = 1'b1;
            end
            if (cif_r != 4'd15) cif_s = cif_r + 4'd1;
          end
        end
      end
      PH_SUM: begin
        if (!hexv[4]) begin
          if (cif_r == 4'd0) fmt_s = 1'b1;
          phase_s = PH_SKIP;
        end else begin
          if (rsum_r[7:4] != 4'd0) ovf_s = 1'b1;
          rsum_s = {rsum_r[3:0], hexv[3:0]};
          if (cif_r != 4'd15) cif_s = cif_r + 4'd1;
        end
      end
      PH_SKIP: begin
      end
      default: begin
      end
    endcase
  end

  // Decode hhmmss and apply the hour offset
  assign n0 = digits_nxt[23:20];
  assign n1 = digits_nxt[19:16];
  assign n2 = digits_nxt[15:12];
  assign n3 = digits_nxt[11:8];
  assign n4 = digits_nxt[7:4];
  assign n5 = digits_nxt[3:0];
  assign digits_ok = (n0 <= 4'd9) && (n1 <= 4'd9) && (n2 <= 4'd9) &&
                     (n3 <= 4'd9) && (n4 <= 4'd9) && (n5 <= 4'd9);
  assign hh = 7'(n0) * 7'd10 + 7'(n1);
  assign mm = 7'(n2) * 7'd10 + 7'(n3);
  assign ss = 7'(n4) * 7'd10 + 7'(n5);
  assign time_ok = digits_ok && (hh <= 7'd23) && (mm <= 7'd59) && (ss <= 7'd60);
  assign hsum = 6'(hh[4:0]) + 6'(hour_offset);
  assign hwrap = (hsum < nrte_pkg::HOURS_DAY)        ? hsum :
                 (hsum < 6'(2 * nrte_pkg::HOURS_DAY)) ? hsum - nrte_pkg::HOURS_DAY :
                 hsum - 6'(2 * nrte_pkg::HOURS_DAY);

  // Grade the sentence in priority order
  assign fmt_end = fmt_s || (phase_s == PH_BODY) || (phase_s == PH_SUM && cif_s == 4'd0);
  always_comb begin
    if (fmt_end) begin
      status = nrte_pkg::ST_FORMAT;
    end else if (ovf_s || rsum_s != xor_s) begin
      status = nrte_pkg::ST_CHECKSUM;
    end else if (!hdr_s) begin
      status = nrte_pkg::ST_NOT_RMC;
    end else if (!act_s) begin
      status = nrte_pkg::ST_NOT_ACTIVE;
    end else if (time_ok) begin
      status = nrte_pkg::ST_ACCEPTED;
    end else begin
      status = nrte_pkg::ST_FORMAT;
    end
  end

  // Close the sentence on its last byte, keep an accepted time
  always_comb begin
    phase_nxt = phase_s;
    xor_nxt   = xor_s;
    rsum_nxt  = rsum_s;
    ovf_nxt   = ovf_s;
    field_nxt = field_s;
    cif_nxt   = cif_s;
    hdr_nxt   = hdr_s;
    act_nxt   = act_s;
    fmt_nxt   = fmt_s;
    khour_nxt = khour_r;
    kmin_nxt  = kmin_r;
    ksec_nxt  = ksec_r;
    have_nxt  = have_r;
    if (last_byte) begin
      if (status == nrte_pkg::ST_ACCEPTED) begin
        khour_nxt = hwrap[4:0];
        kmin_nxt  = mm[5:0];
        ksec_nxt  = ss[5:0];
        have_nxt  = 1'b1;
      end
      phase_nxt = PH_FIRST;
      xor_nxt   = 8'd0;
      rsum_nxt  = 8'd0;
      ovf_nxt   = 1'b0;
      field_nxt = 4'd0;
      cif_nxt   = 4'd0;
      hdr_nxt   = 1'b1;
      act_nxt   = 1'b0;
      fmt_nxt   = 1'b0;
    end
  end

  assign res_valid           = step_en && last_byte;
  assign res.sentence_status = status;
  assign res.time_valid      = have_nxt;
  assign res.local_hour      = khour_nxt;
  assign res.local_minute    = kmin_nxt;
  assign res.local_second    = ksec_nxt;

  // Hold the parse state, update it on every byte that steps through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      xor_r    <= 8'd0;
      rsum_r   <= 8'd0;
      ovf_r    <= 1'b0;
      field_r  <= 4'd0;
      cif_r    <= 4'd0;
      hdr_r    <= 1'b1;
      act_r    <= 1'b0;
      fmt_r    <= 1'b0;
      digits_r <= 24'd0;
      khour_r  <= 5'd0;
      kmin_r   <= 6'd0;
      ksec_r   <= 6'd0;
      have_r   <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      xor_r    <= xor_nxt;
      rsum_r   <= rsum_nxt;
      ovf_r    <= ovf_nxt;
      field_r  <= field_nxt;
      cif_r    <= cif_nxt;
      hdr_r    <= hdr_nxt;
      act_r    <= act_nxt;
      fmt_r    <= fmt_nxt;
      digits_r <= digits_nxt;
      khour_r  <= khour_nxt;
      kmin_r   <= kmin_nxt;
      ksec_r   <= ksec_nxt;
      have_r   <= have_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/nrte_out_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nrte_out_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire nrte_pkg::res_t  res_in,
  output logic                 room,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output logic [2:0]           out_sentence_status,
  output logic                 out_time_valid,
  output logic [4:0]           out_local_hour,
  output logic [5:0]           out_local_minute,
  output logic [5:0]           out_local_second
);

  logic           valid_r, valid_nxt;
  nrte_pkg::res_t word_r;

  // Room for a new word when empty or when the held word leaves now
  assign room = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the result word
  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= res_in;
    end
  end

  assign out_valid           = valid_r;
  assign out_sentence_status = word_r.sentence_status;
  assign out_time_valid      = word_r.time_valid;
  assign out_local_hour      = word_r.local_hour;
  assign out_local_minute    = word_r.local_minute;
  assign out_local_second    = word_r.local_second;

endmodule

`default_nettype wire

// ----- rtl/core/nmea_rmc_time_extractor_top.sv -----
// Flow: a byte taken into the input register reaches the parser register as it leaves;
//   a sentence's status word enters the output register as its last byte leaves it.
// Throughput: one byte per cycle; the input register holds a last byte only
//   while the output register is full and not being taken.
// Reset (synchronous, rst_n low): parser idle awaiting '$', no kept time,
//   hour offset 8, input and output registers empty.
`timescale 1ns / 1ps
`default_nettype none
`include "nmea_rmc_time_extractor_top_macros.svh"

module nmea_rmc_time_extractor_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [4:0] cfg_hour_offset,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_sentence_status,
  output logic            out_time_valid,
  output logic [4:0]      out_local_hour,
  output logic [5:0]      out_local_minute,
  output logic [5:0]      out_local_second
);

  logic [4:0]     offset_r;
  logic           s1_valid_r, s1_valid_nxt;
  logic [7:0]     s1_byte_r;
  logic           s1_last_r;
  logic           advance, room, res_valid;
  nrte_pkg::res_t res;

  // Configuration register, always writable
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= nrte_pkg::OFFSET_RESET;
    end else if (cfg_valid) begin
      offset_r <= cfg_hour_offset;
    end
  end

  // Input register: advance unless a last byte meets a stalled output
  assign advance  = s1_valid_r && (!s1_last_r || room);
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  nrte_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .data_byte   (s1_byte_r),
    .last_byte   (s1_last_r),
    .hour_offset (offset_r),
    .res         (res),
    .res_valid   (res_valid)
  );

  nrte_out_reg u_out (
    .clk                 (clk),
    .rst_n               (rst_n),
    .load                (res_valid),
    .res_in              (res),
    .room                (room),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_sentence_status (out_sentence_status),
    .out_time_valid      (out_time_valid),
    .out_local_hour      (out_local_hour),
    .out_local_minute    (out_local_minute),
    .out_local_second    (out_local_second)
  );

  // An accepted sentence always carries a kept time
  `NRTE_ASSERT_NOW(a_accept_has_time,
    out_valid && out_sentence_status == nrte_pkg::ST_ACCEPTED, out_time_valid)
  // A kept hour is always within the day
  `NRTE_ASSERT_NOW(a_hour_in_day, out_valid && out_time_valid, out_local_hour <= 5'd23)
  // A last byte facing a full, stalled output is held, not dropped
  `NRTE_ASSERT_NEXT(a_last_held,
    s1_valid_r && s1_last_r && out_valid && !out_ready, s1_valid_r && s1_last_r)

endmodule

`default_nettype wire

// ----- sim/nmea_rmc_time_extractor_top_test.sv -----
`timescale 1ns / 1ps

module nmea_rmc_time_extractor_top_test;

  localparam int        SETTLE_CYCLES = 8;
  localparam int        BYTE_TARGET   = 1750;
  localparam logic [39:0] RMC_ID      = "GPRMC";

  typedef enum logic [1:0] {PH_OPEN, PH_BODY, PH_SUM, PH_SKIP} rmc_phase_t;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       cfg_valid       = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_hour_offset = 5'd0;
  logic       in_valid        = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte    = 8'h00;
  logic       in_last_byte    = 1'b0;
  logic       out_valid;
  logic       out_ready       = 1'b0;
  logic [2:0] out_sentence_status;
  logic       out_time_valid;
  logic [4:0] out_local_hour;
  logic [5:0] out_local_minute;
  logic [5:0] out_local_second;

  // Parser shadow state
  rmc_phase_t phase;
  logic [7:0] sum_acc, sum_rx;
  logic       sum_big, hdr_ok, act_seen, fmt_err;
  logic [3:0] fld_no, fld_pos;
  logic [23:0] clk_digits;
  logic [4:0] kept_hr, hr_shift;
  logic [5:0] kept_min, kept_sec;
  logic       kept_ok;

  nrte_pkg::res_t status_due_q[$];
  bit   no_idle = 1'b0;
  int   sink_hold = 0;
  int   bytes_sent = 0, sentences_sent = 0, words_checked = 0;
  int   times_taken = 0, mismatch_cnt = 0, offset_writes = 0;

  nmea_rmc_time_extractor_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_hour_offset     (cfg_hour_offset),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_sentence_status (out_sentence_status),
    .out_time_valid      (out_time_valid),
    .out_local_hour      (out_local_hour),
    .out_local_minute    (out_local_minute),
    .out_local_second    (out_local_second)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Pick an idle stretch: mostly none, sometimes short, rarely long
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Clear the per-sentence parse state
  function automatic void clear_sentence();
    phase    = PH_OPEN;
    sum_acc  = 8'h00;
    sum_rx   = 8'h00;
    sum_big  = 1'b0;
    fld_no   = 4'd0;
    fld_pos  = 4'd0;
    hdr_ok   = 1'b1;
    act_seen = 1'b0;
    fmt_err  = 1'b0;
  endfunction

  // Field 0 must have held exactly five characters
  function automatic void close_field();
    if (fld_no == 4'd0 && fld_pos != 4'd5) hdr_ok = 1'b0;
  endfunction

  // Advance the shadow parser by one accepted byte; emit a status word on the last one
  function automatic void rmc_parse_byte(input logic [7:0] b, input logic last,
                                         output bit emit, output nrte_pkg::res_t r);
    logic [3:0] hx_v;
    logic       hx_ok;
    int         idx, hh, mm, ss, k;
    bit         ok;
    logic [2:0] st;
    emit = 1'b0;
    r    = '0;
    case (phase)
      PH_OPEN: begin
        clk_digits = 24'hFFFFFF;
        if (b == nrte_pkg::CH_DOLLAR) begin
          phase = PH_BODY;
        end else begin
          fmt_err = 1'b1;
          phase   = PH_SKIP;
        end
      end
      PH_BODY: begin
        if (b == nrte_pkg::CH_STAR) begin
          if (fld_no == 4'd0 && fld_pos == 4'd0) fmt_err = 1'b1;
          close_field();
          phase   = PH_SUM;
          fld_pos = 4'd0;
        end else begin
          sum_acc = sum_acc ^ b;
          if (b == nrte_pkg::CH_COMMA) begin
            close_field();
            if (fld_no < 4'd15) fld_no = fld_no + 4'd1;
            fld_pos = 4'd0;
          end else begin
            if (fld_no == 4'd0) begin
              idx = 4 - int'(fld_pos);
              if (fld_pos >= 4'd5 || RMC_ID[8*idx +: 8] != b) hdr_ok = 1'b0;
            end else if (fld_no == 4'd1) begin
              if (fld_pos < 4'd6) begin
                idx = 5 - int'(fld_pos);
                clk_digits[4*idx +: 4] = (b >= "0" && b <= "9") ? 4'(b - "0") : 4'hF;
              end
            end else if (fld_no == 4'd2) begin
              if (fld_pos == 4'd0 && b == nrte_pkg::CH_ACTIVE) act_seen = 1'b1;
            end
            if (fld_pos < 4'd15) fld_pos = fld_pos + 4'd1;
          end
        end
      end
      PH_SUM: begin
        hx_ok = 1'b1;
        hx_v  = 4'h0;
        if (b >= "0" && b <= "9") hx_v = 4'(b - "0");
        else if (b >= "A" && b <= "F") hx_v = 4'(b - "A" + 8'd10);
        else if (b >= "a" && b <= "f") hx_v = 4'(b - "a" + 8'd10);
        else hx_ok = 1'b0;
        if (!hx_ok) begin
          if (fld_pos == 4'd0) fmt_err = 1'b1;
          phase = PH_SKIP;
        end else begin
          if (sum_rx[7:4] != 4'h0) sum_big = 1'b1;
          sum_rx = {sum_rx[3:0], hx_v};
          if (fld_pos < 4'd15) fld_pos = fld_pos + 4'd1;
        end
      end
      default: ;
    endcase

    if (!last) return;

    if (phase == PH_BODY || (phase == PH_SUM && fld_pos == 4'd0)) fmt_err = 1'b1;

    if (fmt_err) begin
      st = nrte_pkg::ST_FORMAT;
    end else if (sum_big || sum_rx != sum_acc) begin
      st = nrte_pkg::ST_CHECKSUM;
    end else if (!hdr_ok) begin
      st = nrte_pkg::ST_NOT_RMC;
    end else if (!act_seen) begin
      st = nrte_pkg::ST_NOT_ACTIVE;
    end else begin
      ok = 1'b1;
      for (k = 0; k < 6; k++)
        if (clk_digits[4*(5-k) +: 4] > 4'd9) ok = 1'b0;
      hh = 10 * int'(clk_digits[23:20]) + int'(clk_digits[19:16]);
      mm = 10 * int'(clk_digits[15:12]) + int'(clk_digits[11:8]);
      ss = 10 * int'(clk_digits[7:4])   + int'(clk_digits[3:0]);
      if (hh > 23 || mm > 59 || ss > 60) ok = 1'b0;
      if (ok) begin
        kept_hr  = 5'((hh + int'(hr_shift)) % int'(nrte_pkg::HOURS_DAY));
        kept_min = 6'(mm);
        kept_sec = 6'(ss);
        kept_ok  = 1'b1;
        st       = nrte_pkg::ST_ACCEPTED;
      end else begin
        st = nrte_pkg::ST_FORMAT;
      end
    end

    r.sentence_status = st;
    r.time_valid      = kept_ok;
    r.local_hour      = kept_hr;
    r.local_minute    = kept_min;
    r.local_second    = kept_sec;
    emit = 1'b1;
    clear_sentence();
  endfunction

  // Check each status word against the oldest prediction, and stall the sink at random
  always @(posedge clk) begin : sink_check
    nrte_pkg::res_t seen, want;
    if (rst_n && out_valid && out_ready) begin
      seen.sentence_status = out_sentence_status;
      seen.time_valid      = out_time_valid;
      seen.local_hour      = out_local_hour;
      seen.local_minute    = out_local_minute;
      seen.local_second    = out_local_second;
      words_checked++;
      if (status_due_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("[%0t] unexpected word: status %0d valid %0d %0d:%0d:%0d", $realtime,
                   seen.sentence_status, seen.time_valid, seen.local_hour,
                   seen.local_minute, seen.local_second);
      end else begin
        want = status_due_q.pop_front();
        if (want.sentence_status == nrte_pkg::ST_ACCEPTED) times_taken++;
        if (seen.sentence_status != want.sentence_status ||
            seen.time_valid != want.time_valid ||
            seen.local_hour != want.local_hour ||
            seen.local_minute != want.local_minute ||
            seen.local_second != want.local_second) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"[%0t] word mismatch: exp status %0d valid %0d %0d:%0d:%0d, ",
                      "got status %0d valid %0d %0d:%0d:%0d"},
                     $realtime, want.sentence_status, want.time_valid, want.local_hour,
                     want.local_minute, want.local_second, seen.sentence_status,
                     seen.time_valid, seen.local_hour, seen.local_minute,
                     seen.local_second);
        end
      end
    end
    // Hold the sink off for a random stretch, then release it
    if (sink_hold > 0) begin
      out_ready <= 1'b0;
      sink_hold--;
    end else begin
      out_ready <= 1'b1;
      sink_hold = idle_len();
    end
  end

  // Offer one byte, hold it until taken, then predict its effect
  task automatic send_byte(input logic [7:0] b, input logic last);
    int   gap;
    bit   emit;
    nrte_pkg::res_t r;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rmc_parse_byte(b, last, emit, r);
    if (emit) status_due_q.push_back(r);
    bytes_sent++;
  endtask

  // Send a whole sentence, marking its final character
  task automatic send_line(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    sentences_sent++;
  endtask

  // Drop valid and wait until every predicted word has been taken
  task automatic settle();
    in_valid <= 1'b0;
    while (status_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the hour offset once the block has gone quiet
  task automatic write_offset(input logic [4:0] v);
    settle();
    cfg_valid       <= 1'b1;
    cfg_hour_offset <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    hr_shift = v;
    offset_writes++;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] body_xor(input string body);
    logic [7:0] x;
    int i;
    x = 8'h00;
    for (i = 0; i < body.len(); i++) x = x ^ body[i];
    return x;
  endfunction

  // Frame a body with '$' and its checksum
  function automatic string framed(input string body, input bit lower);
    if (lower) return $sformatf("$%s*%02x", body, body_xor(body));
    return $sformatf("$%s*%02X", body, body_xor(body));
  endfunction

  // Printable text free of commas and stars
  function automatic string rand_text(input int n);
    string s;
    byte   c;
    int    i;
    s = "";
    for (i = 0; i < n; i++) begin
      c = byte'($urandom_range(33, 126));
      if (c == nrte_pkg::CH_COMMA || c == nrte_pkg::CH_STAR) c = "x";
      s = $sformatf("%s%c", s, c);
    end
    return s;
  endfunction

  function automatic string rmc_body(input string hdr, input int hh, input int mm,
                                     input int ss, input string f2, input int extra);
    string s;
    int    i;
    s = $sformatf("%s,%02d%02d%02d.%02d,%s", hdr, hh, mm, ss, $urandom_range(0, 99), f2);
    for (i = 0; i < extra; i++) s = {s, ",", rand_text($urandom_range(0, 6))};
    return s;
  endfunction

  task automatic test_power_on();
    // Reject first so the empty kept time shows, then accept at the reset offset
    send_line(framed("GPRMC,123519,V,4807.038,N", 1'b0));
    send_line(framed("GPRMC,123519,A,4807.038,N,01131.000,E", 1'b0));
    send_line(framed("GPRMC,235959.99,A", 1'b0));
  endtask

  task automatic test_framing();
    send_line("GPRMC,010203,A*00");
    send_line("x");
    send_line("$");
    send_line("$*00");
    send_line("$GPRMC,010203,A");
    send_line("$GPRMC,010203,A*");
    send_line("$GPRMC,010203,A*\r\n");
    send_line("$GPRMC,010203,A*G1");
  endtask

  task automatic test_checksum();
    string b;
    b = "GPRMC,111111,A,,,";
    send_line(framed(b, 1'b1));
    send_line({framed(b, 1'b0), "\r\n"});
    send_line($sformatf("$%s*00%02X", b, body_xor(b)));
    send_line($sformatf("$%s*1%02X", b, body_xor(b)));
    send_line($sformatf("$%s*%02X", b, body_xor(b) ^ 8'h80));
    send_line($sformatf("$%s*%1X", b, body_xor(b) & 8'h0F));
  endtask

  task automatic test_header();
    send_line(framed("GPGGA,010203,A", 1'b0));
    send_line(framed("GPRM,010203,A", 1'b0));
    send_line(framed("GPRMCX,010203,A", 1'b0));
    send_line(framed(",010203,A", 1'b0));
  endtask

  task automatic test_active();
    send_line(framed("GPRMC,020304", 1'b0));
    send_line(framed("GPRMC,020304,", 1'b0));
    send_line(framed("GPRMC,020304,VA", 1'b0));
    send_line(framed("GPRMC,020304,AV", 1'b0));
  endtask

  task automatic test_time_field();
    send_line(framed("GPRMC,240000,A", 1'b0));
    send_line(framed("GPRMC,236000,A", 1'b0));
    send_line(framed("GPRMC,235961,A", 1'b0));
    send_line(framed("GPRMC,235960,A", 1'b0));
    send_line(framed("GPRMC,12345,A", 1'b0));
    send_line(framed("GPRMC,12a456,A", 1'b0));
    send_line(framed("GPRMC,,A", 1'b0));
    send_line(framed("GPRMC,0000001234567890123,A", 1'b0));
  endtask

  task automatic test_field_count();
    send_line(framed("GPRMC,101010,A,,,,,,,,,,,,,,,,,,,1,2", 1'b0));
    send_line(framed("GPRMCGPRMCGPRMCGPRMC,101010,A", 1'b0));
  endtask

  task automatic test_offsets();
    logic [4:0] vals[4];
    int i;
    vals = '{5'd0, 5'd23, 5'd24, 5'd31};
    for (i = 0; i < 4; i++) begin
      write_offset(vals[i]);
      send_line(framed("GPRMC,230000,A", 1'b0));
      send_line(framed("GPRMC,000000,A", 1'b0));
    end
  endtask

  // Random sentences, mostly well formed, the rest broken or noise
  task automatic test_random();
    string s, b, hdrs[6];
    int    r, n, i, hh, mm, ss;
    hdrs = '{"GPGGA", "GNRMC", "GPRM", "GPRMCA", "gprmc", ""};
    while (bytes_sent < BYTE_TARGET) begin
      // Toggle stretches with no idling now and then
      if ($urandom_range(0, 99) < 8) no_idle = !no_idle;
      r = $urandom_range(0, 999);
      if (r < 15) write_offset(5'($urandom_range(0, 31)));
      else if (r < 40) settle();

      hh = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 29) : $urandom_range(0, 23);
      mm = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
      ss = ($urandom_range(0, 19) == 0) ? $urandom_range(61, 99) : $urandom_range(0, 60);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        n = $urandom_range(0, 19);
        b = rmc_body("GPRMC", hh, mm, ss, (n < 16) ? "A" : (n < 18) ? "V" : "", 
                     $urandom_range(0, 10));
        if ($urandom_range(0, 9) == 0)
          s = $sformatf("$%s*%02X", b, body_xor(b) ^ 8'($urandom_range(1, 255)));
        else
          s = framed(b, $urandom_range(0, 1));
        if ($urandom_range(0, 1)) s = {s, "\r\n"};
        send_line(s);
      end else if (r < 76) begin
        send_line(framed(rmc_body(hdrs[$urandom_range(0, 5)], hh, mm, ss, "A", 2), 1'b0));
      end else if (r < 82) begin
        b = {"GPRMC,", rand_text($urandom_range(0, 8)), ",A"};
        send_line(framed(b, 1'b0));
      end else if (r < 86) begin
        b = rmc_body("GPRMC", hh, mm, ss, "A", 1);
        case ($urandom_range(0, 2))
          0:       send_line({"$", b});
          1:       send_line({"$", b, "*"});
          default: send_line($sformatf("$%s*%1X%02X", b, $urandom_range(0, 15), body_xor(b)));
        endcase
      end else if (r < 90) begin
        s = framed(rmc_body("GPRMC", hh, mm, ss, "A", 1), 1'b0);
        send_line(s.substr(1, s.len() - 1));
      end else if (r < 94) begin
        b = rmc_body("GPRMC", hh, mm, ss, "A", $urandom_range(14, 20));
        send_line(framed(b, 1'b0));
      end else begin
        // Raw bytes over the whole range, often opened with '$'
        n = $urandom_range(1, 30);
        for (i = 0; i < n; i++)
          send_byte((i == 0 && $urandom_range(0, 1)) ? nrte_pkg::CH_DOLLAR
                                                     : 8'($urandom_range(0, 255)),
                    i == n - 1);
        sentences_sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clear_sentence();
    clk_digits = 24'h000000;
    kept_hr    = 5'd0;
    kept_min   = 6'd0;
    kept_sec   = 6'd0;
    kept_ok    = 1'b0;
    hr_shift   = nrte_pkg::OFFSET_RESET;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_on();
    test_framing();
    test_checksum();
    test_header();
    test_active();
    test_time_field();
    test_field_count();
    test_offsets();
    write_offset(nrte_pkg::OFFSET_RESET);
    test_random();
    settle();

    $display("Run covered %0d sentences in %0d bytes; %0d status words checked, %0d accepted.",
             sentences_sent, bytes_sent, words_checked, times_taken);
    $display("Hour offset written %0d times, extremes 0 and 31 included; %0d mismatches.",
             offset_writes, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Bound the run in case the block hangs
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
